// ----- hdl/prescaled_match_timer_top_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef PRESCALED_MATCH_TIMER_TOP_DEFINES_SVH
`define PRESCALED_MATCH_TIMER_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define PMT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmt assertion failed");

// Next-cycle implication, masked during reset.
`define PMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmt assertion failed");

// Next-cycle implication that also holds across reset.
`define PMT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pmt assertion failed");

`endif

// ----- hdl/pmt_pkg.sv -----
`default_nettype none
package pmt_pkg;

   localparam int DATA_W       = 32;
   localparam int OP_W         = 2;
   localparam int IDX_W        = 3;
   localparam int MAX_CHANNELS = 4;
   localparam int EN_STRIDE    = 3;

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

   localparam logic [IDX_W-1:0] REG_RUN    = 3'd0;
   localparam logic [IDX_W-1:0] REG_COUNT  = 3'd1;
   localparam logic [IDX_W-1:0] REG_ENABLE = 3'd2;
   localparam logic [IDX_W-1:0] REG_FLAGS  = 3'd3;

endpackage
`default_nettype wire

// ----- hdl/pmt_req_if.sv -----
`default_nettype none
interface pmt_req_if;
   logic                      valid;
   logic                      ready;
   logic [pmt_pkg::OP_W-1:0]  op;
   logic [pmt_pkg::IDX_W-1:0] reg_index;
   logic [pmt_pkg::DATA_W-1:0] write_data;

   modport source (output valid, op, reg_index, write_data, input ready);
   modport sink   (input valid, op, reg_index, write_data, output ready);
endinterface
`default_nettype wire

// ----- hdl/pmt_rsp_if.sv -----
`default_nettype none
interface pmt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pmt_pkg::DATA_W-1:0] read_data;
   logic                       irq_pending;

   modport source (output valid, read_data, irq_pending, input ready);
   modport sink   (input valid, read_data, irq_pending, output ready);
endinterface
`default_nettype wire

// ----- hdl/pmt_csr_if.sv -----
`default_nettype none
interface pmt_csr_if;
   logic                       valid;
   logic                       ready;
   logic [pmt_pkg::DATA_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/prescaled_match_timer_top.sv -----
`default_nettype none
// 32-bit timer with a prescaler and CHANNELS match channels.
// req_if carries one beat per operation: a clock tick, a register read or a
// register write (op, reg_index, write_data). rsp_if returns exactly one beat
// for each request beat, in order: read_data (zero unless a read) and
// irq_pending (any match flag set after the operation).
// csr_if writes the prescale register; it is always ready and should only be
// written while no request is in flight.
// The response to each accepted request is held in a response register.
// Throughput: one request per cycle while responses are taken; the single
// response register is the only storage between the channels, so
// req_if.ready follows !rsp_if.valid || rsp_if.ready.
// When the receiver stalls, the response holds and one more request can not
// enter until that response beat is taken.
// Reset (synchronous) stops the timer, clears counts, match values, enables,
// flags and the prescale register, and drops rsp_if.valid.
module prescaled_match_timer_top #(
   parameter int CHANNELS = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pmt_req_if.sink     req_if,
   pmt_rsp_if.source   rsp_if,
   pmt_csr_if.sink     csr_if
);
   import pmt_pkg::*;

   logic [DATA_W-1:0]   prescale_ff;
   logic [DATA_W-1:0]   pcount_ff,  pcount_in;
   logic [DATA_W-1:0]   tcount_ff,  tcount_in;
   logic                run_ff,     run_in;
   logic [DATA_W-1:0]   match_ff [CHANNELS];
   logic [DATA_W-1:0]   match_in [CHANNELS];
   logic [CHANNELS-1:0] enable_ff,  enable_in;
   logic [CHANNELS-1:0] flags_ff,   flags_in;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   read_data_ff, read_data_in;
   logic                irq_ff;
   logic                req_accept;
   logic                chan_sel;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.read_data   = read_data_ff;
   assign rsp_if.irq_pending = irq_ff;

   assign chan_sel = req_if.reg_index[IDX_W-1];

   always_comb begin
      pcount_in    = pcount_ff;
      tcount_in    = tcount_ff;
      run_in       = run_ff;
      enable_in    = enable_ff;
      flags_in     = flags_ff;
      read_data_in = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         match_in[c] = match_ff[c];
      end

      case (req_if.op)
         OP_TICK: begin
            if (run_ff) begin
               // end of prescale period: wrap prescaler, advance count, check matches
               if (pcount_ff >= prescale_ff) begin
                  pcount_in = '0;
                  tcount_in = tcount_ff + 1'b1;
                  for (int c = 0; c < CHANNELS; c++) begin
                     if (enable_ff[c] && (tcount_in == match_ff[c])) begin
                        flags_in[c] = 1'b1;
                     end
                  end
               end else begin
                  pcount_in = pcount_ff + 1'b1;
               end
            end
         end
         OP_READ: begin
            case (req_if.reg_index)
               REG_RUN:    read_data_in = {{(DATA_W-1){1'b0}}, run_ff};
               REG_COUNT:  read_data_in = tcount_ff;
               REG_ENABLE: begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     read_data_in[c*EN_STRIDE] = enable_ff[c];
                  end
               end
               REG_FLAGS:  read_data_in = {{(DATA_W-CHANNELS){1'b0}}, flags_ff};
               default: begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     if (chan_sel && (req_if.reg_index[IDX_W-2:0] == (IDX_W-1)'(c))) begin
                        read_data_in = match_ff[c];
                     end
                  end
               end
            endcase
         end
         OP_WRITE: begin
            case (req_if.reg_index)
               REG_RUN:    run_in = req_if.write_data[0];
               REG_COUNT:  run_in = run_ff;
               REG_ENABLE: begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     enable_in[c] = req_if.write_data[c*EN_STRIDE];
                  end
               end
               // write one to clear
               REG_FLAGS:  flags_in = flags_ff & ~req_if.write_data[CHANNELS-1:0];
               default: begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     if (chan_sel && (req_if.reg_index[IDX_W-2:0] == (IDX_W-1)'(c))) begin
                        match_in[c] = req_if.write_data;
                     end
                  end
               end
            endcase
         end
         default: read_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff  <= '0;
         pcount_ff    <= '0;
         tcount_ff    <= '0;
         run_ff       <= 1'b0;
         enable_ff    <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            match_ff[c] <= '0;
         end
      end else begin
         if (csr_if.valid) begin
            prescale_ff <= csr_if.data;
         end
         if (req_accept) begin
            pcount_ff    <= pcount_in;
            tcount_ff    <= tcount_in;
            run_ff       <= run_in;
            enable_ff    <= enable_in;
            flags_ff     <= flags_in;
            rsp_valid_ff <= 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
               match_ff[c] <= match_in[c];
            end
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, loaded with each accepted beat
   always_ff @(posedge clock) begin
      if (req_accept) begin
         read_data_ff <= read_data_in;
         irq_ff       <= |flags_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/pmt_checker.sv -----
`default_nettype none
`include "prescaled_match_timer_top_defines.svh"
module pmt_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic [pmt_pkg::OP_W-1:0]   req_op,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [pmt_pkg::DATA_W-1:0] rsp_read_data
);
   import pmt_pkg::*;

   logic req_beat;
   logic rsp_stall;

   assign req_beat  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   `PMT_ASSERT_NEXT_ALWAYS(a_reset_drops_rsp, clock, reset, !rsp_valid)
   `PMT_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_beat, rsp_valid)
   `PMT_ASSERT_SAME(a_no_accept_while_stalled, clock, reset, rsp_stall, !req_ready)
   `PMT_ASSERT_NEXT(a_nonread_zero, clock, reset, req_beat && (req_op != OP_READ), rsp_read_data == '0)
   `PMT_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_stall, rsp_valid)

endmodule

bind prescaled_match_timer_top pmt_checker u_pmt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_op        (req_if.op),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_read_data (rsp_if.read_data)
);
`default_nettype wire
